// ===== src/fraction_arith_reduce_top_assert.svh =====
// ----------------------------------------------------------------------------
// Fraction arithmetic assertion macros
// Concurrent checks used by the fraction reduction block; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ARITH_REDUCE_TOP_ASSERT_SVH
`define FRACTION_ARITH_REDUCE_TOP_ASSERT_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define FRA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fra: check failed");
// expression must never be true out of reset
`define FRA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fra: forbidden condition");
`else
`define FRA_ASSERT(lbl, clk, rst_n, prop)
`define FRA_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== src/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic package
// Widths, operation codes, queue entry and back-end state types.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

    localparam int OPW    = 16;        // operand width
    localparam int PW     = 2 * OPW;   // product width
    localparam int NW     = PW + 1;    // raw numerator width
    localparam int DW     = PW;        // raw denominator width
    localparam int CW     = 6;         // step and shift counter width
    localparam int IN_TW  = 72;
    localparam int OUT_TW = 72;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [NW-1:0] num;
        logic signed [DW-1:0] den;
        logic                 err;
    } raw_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EVEN,
        B_AODD,
        B_LOOP,
        B_DIV,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic out_load;
    } back_ctl_t;

endpackage

`default_nettype wire

// ===== src/fra_front.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic front end
// Accepts beats, forms cross products, builds the raw fraction and flags zero
// denominators before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [fra_pkg::IN_TW-1:0]  s_tdata,
    input  wire fra_pkg::q_stat_t           q_stat,
    output logic                            push,
    output fra_pkg::raw_t                   push_data
);
    import fra_pkg::*;

    logic signed [OPW-1:0] a_num, a_den, b_num, b_den;
    op_t                   kind;
    logic                  accept;

    logic                  p_valid_reg, p_valid_next;
    op_t                   kind_reg;
    logic signed [PW-1:0]  andb_reg, adbn_reg, anbn_reg, adbd_reg;

    logic signed [NW-1:0]  x_andb, x_adbn;

    assign kind  = op_t'(s_tdata[1:0]);
    assign a_num = signed'(s_tdata[17:2]);
    assign a_den = signed'(s_tdata[33:18]);
    assign b_num = signed'(s_tdata[49:34]);
    assign b_den = signed'(s_tdata[65:50]);

    assign push     = p_valid_reg && !q_stat.full;
    assign s_tready = !p_valid_reg || !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (push) begin
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind;
            andb_reg <= a_num * b_den;
            adbn_reg <= a_den * b_num;
            anbn_reg <= a_num * b_num;
            adbd_reg <= a_den * b_den;
        end
    end

    assign x_andb = {andb_reg[PW-1], andb_reg};
    assign x_adbn = {adbn_reg[PW-1], adbn_reg};

    always_comb begin
        unique case (kind_reg)
            OP_ADD: begin
                push_data.num = x_andb + x_adbn;
                push_data.den = adbd_reg;
            end
            OP_SUB: begin
                push_data.num = x_andb - x_adbn;
                push_data.den = adbd_reg;
            end
            OP_MUL: begin
                push_data.num = {anbn_reg[PW-1], anbn_reg};
                push_data.den = adbd_reg;
            end
            default: begin
                push_data.num = x_andb;
                push_data.den = adbn_reg;
            end
        endcase
        push_data.err = (push_data.den == '0);
    end

endmodule

`default_nettype wire

// ===== src/fra_queue.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic queue
// Two-entry show-ahead queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_arith_reduce_top_assert.svh"

module fra_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire fra_pkg::raw_t  push_data,
    input  wire logic           pop,
    output fra_pkg::raw_t       pop_data,
    output fra_pkg::q_stat_t    q_stat
);
    import fra_pkg::*;

    raw_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `FRA_NEVER(a_no_overflow, aclk, aresetn, push && q_stat.full)
    `FRA_NEVER(a_no_underflow, aclk, aresetn, pop && q_stat.empty)
    `FRA_NEVER(a_count_range, aclk, aresetn, count_reg == 2'd3)

endmodule

`default_nettype wire

// ===== src/fra_back.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic back end
// Binary GCD of the magnitudes, two bit-serial exact divisions, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_arith_reduce_top_assert.svh"

module fra_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire fra_pkg::q_stat_t            q_stat,
    input  wire fra_pkg::raw_t               pop_data,
    output logic                             pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [fra_pkg::OUT_TW-1:0]       m_tdata,
    output logic [1:0]                       m_tuser
);
    import fra_pkg::*;

    back_state_t state_reg, state_next;
    back_ctl_t   ctl;
    logic        out_free;

    logic [NW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [CW-1:0]   k_reg, k_next, cnt_reg, cnt_next;
    logic [NW-1:0]   g_reg, g_next;
    logic [NW-1:0]   qn_reg, qn_next, qd_reg, qd_next;
    logic [NW-1:0]   rn_reg, rn_next, rd_reg, rd_next;
    logic            sn_reg, sn_next, sd_reg, sd_next, err_reg, err_next;

    logic [NW-1:0]   mag_num, mag_den;
    logic [NW:0]     trn, trd;

    logic                  out_valid_reg, out_valid_next;
    logic signed [NW-1:0]  onum_reg;
    logic signed [DW-1:0]  oden_reg;
    logic                  oint_reg, oerr_reg;
    logic signed [NW-1:0]  fin_num;
    logic signed [DW-1:0]  fin_den;

    assign out_free = !out_valid_reg || m_tready;
    assign mag_num  = pop_data.num[NW-1] ? NW'(-pop_data.num) : NW'(pop_data.num);
    assign mag_den  = pop_data.den[DW-1] ? {1'b0, DW'(-pop_data.den)} : {1'b0, pop_data.den};
    assign trn      = {rn_reg, qn_reg[NW-1]};
    assign trd      = {rd_reg, qd_reg[NW-1]};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    if (pop_data.err) begin
                        state_next = B_DONE;
                    end else if (mag_num == '0) begin
                        state_next = B_DIV;
                    end else begin
                        state_next = B_EVEN;
                    end
                end
            end
            B_EVEN: if (a_reg[0] || b_reg[0]) state_next = B_AODD;
            B_AODD: if (a_reg[0]) state_next = B_LOOP;
            B_LOOP: if (b_reg == '0) state_next = B_DIV;
            B_DIV:  if (cnt_reg == CW'(NW - 1)) state_next = B_DONE;
            B_DONE: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctl.pop      = (state_reg == B_IDLE) && !q_stat.empty;
        ctl.out_load = (state_reg == B_DONE) && out_free;
    end
    assign pop = ctl.pop;

    // datapath
    always_comb begin
        a_next   = a_reg;
        b_next   = b_reg;
        k_next   = k_reg;
        cnt_next = cnt_reg;
        g_next   = g_reg;
        qn_next  = qn_reg;
        qd_next  = qd_reg;
        rn_next  = rn_reg;
        rd_next  = rd_reg;
        sn_next  = sn_reg;
        sd_next  = sd_reg;
        err_next = err_reg;
        unique case (state_reg)
            B_IDLE: begin
                a_next   = mag_num;
                b_next   = mag_den;
                g_next   = mag_den;
                k_next   = '0;
                cnt_next = '0;
                qn_next  = mag_num;
                qd_next  = mag_den;
                rn_next  = '0;
                rd_next  = '0;
                sn_next  = pop_data.num[NW-1];
                sd_next  = pop_data.den[DW-1];
                err_next = pop_data.err;
            end
            B_EVEN: begin
                if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            B_AODD: begin
                if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end
            end
            B_LOOP: begin
                if (b_reg == '0) begin
                    g_next = a_reg << k_reg;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_reg > b_reg) begin
                    a_next = b_reg;
                    b_next = a_reg - b_reg;
                end else begin
                    b_next = b_reg - a_reg;
                end
            end
            B_DIV: begin
                // restoring step, one quotient bit per cycle on each side
                if (trn >= {1'b0, g_reg}) begin
                    rn_next = NW'(trn - {1'b0, g_reg});
                    qn_next = {qn_reg[NW-2:0], 1'b1};
                end else begin
                    rn_next = trn[NW-1:0];
                    qn_next = {qn_reg[NW-2:0], 1'b0};
                end
                if (trd >= {1'b0, g_reg}) begin
                    rd_next = NW'(trd - {1'b0, g_reg});
                    qd_next = {qd_reg[NW-2:0], 1'b1};
                end else begin
                    rd_next = trd[NW-1:0];
                    qd_next = {qd_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        g_reg   <= g_next;
        qn_reg  <= qn_next;
        qd_reg  <= qd_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        sn_reg  <= sn_next;
        sd_reg  <= sd_next;
        err_reg <= err_next;
    end

    // output stage
    assign fin_num = err_reg ? '0 : (sn_reg ? NW'(-qn_reg) : qn_reg);
    assign fin_den = err_reg ? '0 : (sd_reg ? DW'(-qd_reg[DW-1:0]) : qd_reg[DW-1:0]);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            onum_reg <= fin_num;
            oden_reg <= fin_den;
            oint_reg <= (fin_den == DW'(1));
            oerr_reg <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TW - NW - DW){1'b0}}, oden_reg, onum_reg};
    assign m_tuser  = {oerr_reg, oint_reg};

    `FRA_ASSERT(a_err_zero, aclk, aresetn,
        (out_valid_reg && oerr_reg) |-> (onum_reg == '0 && oden_reg == '0 && !oint_reg))
    `FRA_NEVER(a_div_by_zero, aclk, aresetn, state_reg == B_DIV && g_reg == '0)
    `FRA_ASSERT(a_int_den, aclk, aresetn, (out_valid_reg && oint_reg) |-> (oden_reg == DW'(1)))

endmodule

`default_nettype wire

// ===== src/fraction_arith_reduce_top.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic with GCD reduction
// Adds, subtracts, multiplies or divides two signed fractions and reduces.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. The front end takes a beat,
// registers the cross products, forms the raw fraction from them and then
// queues it (two entries). The back end takes one item at a time: a binary
// GCD of the magnitudes (one shift or one compare-and-subtract per cycle)
// and then bit-serial exact division of both magnitudes by the GCD; an item
// with a zero raw denominator skips both. The denominator keeps its sign;
// error items return zeros.
`default_nettype none

module fraction_arith_reduce_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // kind[1:0], a_num[17:2], a_den[33:18], b_num[49:34], b_den[65:50], zero pad
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // res_num[32:0], res_den[64:33], zero pad
    output logic [71:0]      m_tdata,
    // is_integer[0], error[1]
    output logic [1:0]       m_tuser
);
    import fra_pkg::*;

    logic    push, pop;
    raw_t    push_data, pop_data;
    q_stat_t q_stat;

    fra_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    fra_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    fra_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/fraction_arith_reduce_top_tb.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic testbench
// Drives random and corner fraction pairs through the stream input, predicts
// the reduced fraction for each beat and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fraction_arith_reduce_top_tb;
    import fra_pkg::*;

    typedef struct packed {
        op_t                kind;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } frac_pair_t;

    typedef struct packed {
        logic [32:0] num;
        logic [31:0] den;
        logic        is_int;
        logic        err;
    } reduced_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    frac_pair_t pending_pairs[$];
    reduced_t   expected_fracs[$];
    int         fail_count;
    int         s_gap;
    int         m_gap;
    logic       hold_sender;
    longint     cycle_count;

    fraction_arith_reduce_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic reduced_t reduce_fraction(frac_pair_t p);
        logic signed [63:0] an, ad, bn, bd, num, den;
        logic [63:0] g, rn, rd;
        reduced_t r;
        an = p.a_num;
        ad = p.a_den;
        bn = p.b_num;
        bd = p.b_den;
        case (p.kind)
            OP_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
            OP_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
            OP_MUL: begin num = an * bn; den = ad * bd; end
            default: begin num = an * bd; den = ad * bn; end
        endcase
        r = '0;
        if (den == 0) begin
            r.err = 1'b1;
            return r;
        end
        g = gcd64(mag64(num), mag64(den));
        rn = mag64(num) / g;
        rd = mag64(den) / g;
        if (num[63]) rn = -rn;
        if (den[63]) rd = -rd;
        r.num = rn[32:0];
        r.den = rd[31:0];
        r.is_int = (rd == 64'd1);
        return r;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'(signed'($urandom_range(0, 8)) - 4);
            1: return 16'h8000 + 16'($urandom_range(0, 2));
            2: return 16'h7fff - 16'($urandom_range(0, 2));
            3: return 16'(($urandom_range(1, 60)) * (1 << $urandom_range(0, 8)));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pair(op_t k, logic [15:0] an, logic [15:0] ad,
                            logic [15:0] bn, logic [15:0] bd);
        frac_pair_t p;
        p.kind = k;
        p.a_num = an;
        p.a_den = ad;
        p.b_num = bn;
        p.b_den = bd;
        pending_pairs.push_back(p);
    endtask

    // driver: one beat at a time, random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_gap    <= 0;
        end else if (s_tvalid && !s_tready) begin
            // hold the beat
        end else begin
            if (s_tvalid) expected_fracs.push_back(reduce_fraction({s_tdata[1:0],
                s_tdata[17:2], s_tdata[33:18], s_tdata[49:34], s_tdata[65:50]}));
            if (s_gap > 0 || hold_sender || pending_pairs.size() == 0) begin
                s_tvalid <= 1'b0;
                if (s_gap > 0) s_gap <= s_gap - 1;
            end else begin
                frac_pair_t p;
                p = pending_pairs.pop_front();
                s_tdata  <= {6'b0, p.b_den, p.b_num, p.a_den, p.a_num, p.kind};
                s_tvalid <= 1'b1;
                s_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                reduced_t got, want;
                got.num = m_tdata[32:0];
                got.den = m_tdata[64:33];
                got.is_int = m_tuser[0];
                got.err = m_tuser[1];
                if (expected_fracs.size() == 0) begin
                    $display("%0t: unexpected result num=%0h den=%0h", $time,
                             got.num, got.den);
                    fail_count++;
                end else begin
                    want = expected_fracs.pop_front();
                    if (got.num !== want.num || got.den !== want.den ||
                        got.is_int !== want.is_int || got.err !== want.err) begin
                        $display("%0t: mismatch expected num=%0h den=%0h int=%b err=%b",
                                 $time, want.num, want.den, want.is_int, want.err);
                        $display("%0t:          actual num=%0h den=%0h int=%b err=%b",
                                 $time, got.num, got.den, got.is_int, got.err);
                        fail_count++;
                    end
                end
                m_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("** fraction_arith_reduce_top: FAILED **");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        hold_sender = 1'b0;
        cycle_count = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;

        // directed: every operation, extremes, zero denominators, zero numerator
        add_pair(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd2);
        add_pair(OP_SUB, 16'd1, 16'd3, 16'd1, 16'd3);
        add_pair(OP_MUL, 16'd2, 16'd3, 16'd3, 16'd2);
        add_pair(OP_DIV, 16'd1, 16'd2, 16'd1, 16'd4);
        add_pair(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_pair(OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        add_pair(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_pair(OP_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_pair(OP_ADD, 16'd5, 16'd0, 16'd1, 16'd2);
        add_pair(OP_MUL, 16'd5, 16'd3, 16'd1, 16'd0);
        add_pair(OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
        add_pair(OP_DIV, 16'd5, 16'd3, 16'd4, 16'd0);
        add_pair(OP_DIV, 16'd5, 16'hfffd, 16'd4, 16'd0);
        add_pair(OP_MUL, 16'd0, 16'd9, 16'd4, 16'hfff9);
        add_pair(OP_MUL, 16'd3, 16'd1, 16'd1, 16'hffff);
        add_pair(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_pair(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        add_pair(OP_DIV, 16'h8000, 16'd1, 16'h8000, 16'd1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // drain the directed part before the random traffic
        wait (pending_pairs.size() == 0 && !s_tvalid && expected_fracs.size() == 0);
        for (int i = 0; i < 900; i++) begin
            add_pair(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                     rand_operand(), rand_operand());
            if (i == 450) begin
                wait (pending_pairs.size() == 0 && !s_tvalid);
                @(posedge aclk);
                hold_sender <= 1'b1;
                wait (expected_fracs.size() == 0);
                @(posedge aclk);
                hold_sender <= 1'b0;
            end
        end
        wait (pending_pairs.size() == 0 && !s_tvalid);
        @(posedge aclk);
        wait (expected_fracs.size() == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && expected_fracs.size() == 0) begin
            $display("** fraction_arith_reduce_top: PASSED **");
        end else begin
            $display("** fraction_arith_reduce_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/fra_pkg.sv
src/fra_front.sv
src/fra_queue.sv
src/fra_back.sv
src/fraction_arith_reduce_top.sv
tb/fraction_arith_reduce_top_tb.sv
